// ----- sv/ir_ring_ball_direction_unit_macros.svh -----
// Assertion macros for the IR ring ball direction unit
`ifndef IR_RING_BALL_DIRECTION_UNIT_MACROS_SVH
`define IR_RING_BALL_DIRECTION_UNIT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define IRBD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define IRBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/irbd_pkg.sv -----
// Package: types, constants and table functions of the IR ring ball direction unit
`timescale 1ns / 1ps
`default_nettype none
package irbd_pkg;

    localparam int SENSORS_DEF  = 16;
    localparam int RAW_W        = 16;
    localparam int RUN_W        = 5;
    localparam int START_W      = 4;
    localparam int ANGLE_W      = 12;
    localparam int CFG_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int STEP_W       = 5;
    localparam int CORDIC_STEPS = 24;
    localparam int VEC_W        = 40;
    localparam int PROD_W       = 44;
    localparam int TENTHS_TURN  = 3600;

    localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISSES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

    localparam logic [CFG_W-1:0] CEILING_RST   = 8'd5;
    localparam logic [CFG_W-1:0] MISSES_RST    = 8'd3;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 8'd2;

    localparam logic signed [63:0] CORDIC_START = 64'sd652032874;

    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    typedef struct packed {
        logic              upd;
        logic              scan;
        logic              prep;
        logic              sum;
        logic              vinit;
        logic              vec;
        logic              mul;
        logic              fin;
        logic [STEP_W-1:0] k;
    } t_cmd;

    typedef struct packed {
        logic [RUN_W-1:0] best_len;
        logic [RUN_W-1:0] run_len;
    } t_stat;

    function automatic logic signed [15:0] to_q15(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end else if (r < -64'sd32768) begin
            r = -64'sd32768;
        end
        return r[15:0];
    endfunction

    // {cos, sin} in Q1.15 of a binary angle, full turn = 2^32
    function automatic logic [31:0] unit_vector(input logic [31:0] ang);
        logic [1:0]         quad;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic signed [15:0] c;
        logic signed [15:0] s;
        quad = ang[31:30];
        z    = {34'd0, ang[29:0]};
        x    = CORDIC_START;
        y    = '0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - $signed({32'd0, ATAN_TURN[i]});
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + $signed({32'd0, ATAN_TURN[i]});
            end
        end
        case (quad)
            2'd0: begin
                c = to_q15(x);
                s = to_q15(y);
            end
            2'd1: begin
                c = to_q15(-y);
                s = to_q15(x);
            end
            2'd2: begin
                c = to_q15(-x);
                s = to_q15(-y);
            end
            default: begin
                c = to_q15(y);
                s = to_q15(-x);
            end
        endcase
        return {c, s};
    endfunction

endpackage
`default_nettype wire

// ----- sv/irbd_ctrl.sv -----
// Controller: sequences debounce, run search, vector sum, atan2 and result hand-off
`timescale 1ns / 1ps
`default_nettype none
module irbd_ctrl #(
    parameter int SENSORS = irbd_pkg::SENSORS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  wire logic          i_stall,
    input  wire irbd_pkg::t_stat i_stat,
    output irbd_pkg::t_cmd     o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,
        S_PREP  = 8'b0000_0100,
        S_SUM   = 8'b0000_1000,
        S_VINIT = 8'b0001_0000,
        S_VEC   = 8'b0010_0000,
        S_MUL   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    localparam logic [irbd_pkg::STEP_W-1:0] SCAN_LAST = irbd_pkg::STEP_W'(2 * SENSORS - 1);
    localparam logic [irbd_pkg::STEP_W-1:0] VEC_LAST  =
        irbd_pkg::STEP_W'(irbd_pkg::CORDIC_STEPS - 1);

    t_state                      r_state, n_state;
    logic [irbd_pkg::STEP_W-1:0] r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;
    logic                        w_accept;
    logic                        w_out_free;

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        o_cmd.k     = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.upd = 1'b1;
                    n_cnt     = '0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == SCAN_LAST) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = (i_stat.best_len == '0) ? S_FIN : S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == i_stat.run_len - 1'b1) begin
                    n_state = S_VINIT;
                end
            end
            S_VINIT: begin
                o_cmd.vinit = 1'b1;
                n_cnt       = '0;
                n_state     = S_VEC;
            end
            S_VEC: begin
                o_cmd.vec = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == VEC_LAST) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ----- sv/irbd_datapath.sv -----
// Datapath: sensor counters, run search, vector sum, CORDIC atan2 and result registers
`timescale 1ns / 1ps
`default_nettype none
module irbd_datapath #(
    parameter int SENSORS = irbd_pkg::SENSORS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire irbd_pkg::t_cmd                   i_cmd,
    output irbd_pkg::t_stat                       o_stat,
    input  wire logic                             i_cfg_we,
    input  wire logic [irbd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [irbd_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic [irbd_pkg::RAW_W-1:0]       i_raw_hits,
    output logic [irbd_pkg::RAW_W-1:0]            o_filtered_bitmap,
    output logic [irbd_pkg::RUN_W-1:0]            o_active_count,
    output logic [irbd_pkg::START_W-1:0]          o_run_start,
    output logic [irbd_pkg::RUN_W-1:0]            o_run_length,
    output logic                                  o_ball_seen,
    output logic [irbd_pkg::ANGLE_W-1:0]          o_angle_tenths
);

    localparam int IW  = $clog2(SENSORS);
    localparam int CLW = $clog2(2 * SENSORS + 1);
    localparam int NW  = $clog2(SENSORS + 1);
    localparam int SW  = 17 + IW;
    localparam int VW  = irbd_pkg::VEC_W;
    localparam int CW  = irbd_pkg::CFG_W;

    logic signed [15:0] w_cos [SENSORS];
    logic signed [15:0] w_sin [SENSORS];

    for (genvar g = 0; g < SENSORS; g++) begin : g_tab
        localparam logic [31:0] ANG = 32'(((64'(g) << 32) + 64'(SENSORS / 2)) / SENSORS);
        localparam logic [31:0] CS  = irbd_pkg::unit_vector(ANG);
        assign w_cos[g] = CS[31:16];
        assign w_sin[g] = CS[15:0];
    end

    logic [CW-1:0]        r_ceiling, r_misses, r_threshold;
    logic [CW-1:0]        r_conf   [SENSORS];
    logic [CW-1:0]        r_streak [SENSORS];
    logic [CW-1:0]        n_conf   [SENSORS];
    logic [CW-1:0]        n_streak [SENSORS];
    logic [SENSORS-1:0]   r_filt, n_filt;
    logic [NW-1:0]        r_count;
    logic [CLW-1:0]       r_cur_len, r_best_len, w_cur_inc;
    logic [IW-1:0]        r_cur_start, r_best_start, w_idx;
    logic [irbd_pkg::STEP_W-1:0] w_idx_full;
    logic                 w_bit;
    logic [irbd_pkg::RUN_W-1:0] r_run_len;
    logic [IW-1:0]        r_idx;
    logic signed [SW-1:0] r_sx, r_sy;
    logic signed [VW-1:0] r_x, r_y, w_x0, w_y0, w_dx, w_dy;
    logic [31:0]          r_z, w_atan;
    logic [irbd_pkg::PROD_W-1:0] r_prod;
    logic [irbd_pkg::ANGLE_W-1:0] w_tenths;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling   <= irbd_pkg::CEILING_RST;
            r_misses    <= irbd_pkg::MISSES_RST;
            r_threshold <= irbd_pkg::THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                irbd_pkg::CFG_CEILING:   r_ceiling   <= i_cfg_data;
                irbd_pkg::CFG_MISSES:    r_misses    <= i_cfg_data;
                irbd_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int g = 0; g < SENSORS; g++) begin
            n_conf[g]   = r_conf[g];
            n_streak[g] = r_streak[g] + 1'b1;
            if (i_raw_hits[g]) begin
                n_streak[g] = '0;
                if (r_conf[g] < r_ceiling) begin
                    n_conf[g] = r_conf[g] + 1'b1;
                end
            end else if (n_streak[g] >= r_misses) begin
                n_streak[g] = '0;
                if (r_conf[g] != '0) begin
                    n_conf[g] = r_conf[g] - 1'b1;
                end
            end
            n_filt[g] = (n_conf[g] >= r_threshold);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < SENSORS; g++) begin
                r_conf[g]   <= '0;
                r_streak[g] <= '0;
            end
        end else if (i_cmd.upd) begin
            for (int g = 0; g < SENSORS; g++) begin
                r_conf[g]   <= n_conf[g];
                r_streak[g] <= n_streak[g];
            end
        end
    end

    assign w_idx_full = (i_cmd.k < irbd_pkg::STEP_W'(SENSORS)) ?
                        i_cmd.k : i_cmd.k - irbd_pkg::STEP_W'(SENSORS);
    assign w_idx      = w_idx_full[IW-1:0];
    assign w_bit      = r_filt[w_idx];
    assign w_cur_inc  = r_cur_len + 1'b1;

    assign w_x0   = VW'(r_sx) <<< 12;
    assign w_y0   = VW'(r_sy) <<< 12;
    assign w_dx   = r_y >>> i_cmd.k;
    assign w_dy   = r_x >>> i_cmd.k;
    assign w_atan = irbd_pkg::ATAN_TURN[i_cmd.k];

    assign w_tenths = r_prod[irbd_pkg::PROD_W-1:32];

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_filt       <= n_filt;
            r_count      <= '0;
            r_cur_len    <= '0;
            r_best_len   <= '0;
            r_cur_start  <= '0;
            r_best_start <= '0;
        end
        if (i_cmd.scan) begin
            if (w_bit) begin
                if (r_cur_len == '0) begin
                    r_cur_start <= w_idx;
                end
                r_cur_len <= w_cur_inc;
                if (w_cur_inc > r_best_len) begin
                    r_best_len   <= w_cur_inc;
                    r_best_start <= (r_cur_len == '0) ? w_idx : r_cur_start;
                end
                if (i_cmd.k < irbd_pkg::STEP_W'(SENSORS)) begin
                    r_count <= r_count + 1'b1;
                end
            end else begin
                r_cur_len <= '0;
            end
        end
        if (i_cmd.prep) begin
            r_run_len <= (r_best_len > CLW'(SENSORS)) ?
                         irbd_pkg::RUN_W'(SENSORS) : irbd_pkg::RUN_W'(r_best_len);
            r_idx     <= r_best_start;
            r_sx      <= '0;
            r_sy      <= '0;
        end
        if (i_cmd.sum) begin
            r_sx  <= r_sx + SW'(w_cos[r_idx]);
            r_sy  <= r_sy + SW'(w_sin[r_idx]);
            r_idx <= (r_idx == IW'(SENSORS - 1)) ? '0 : r_idx + 1'b1;
        end
        if (i_cmd.vinit) begin
            if (r_sx < 0) begin
                r_x <= -w_x0;
                r_y <= -w_y0;
                r_z <= 32'h8000_0000;
            end else begin
                r_x <= w_x0;
                r_y <= w_y0;
                r_z <= '0;
            end
        end
        if (i_cmd.vec) begin
            if (r_y < 0) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
        end
        if (i_cmd.mul) begin
            r_prod <= irbd_pkg::PROD_W'(r_z) * irbd_pkg::PROD_W'(irbd_pkg::TENTHS_TURN)
                      + irbd_pkg::PROD_W'(33'h1_0000_0000 >> 1);
        end
        if (i_cmd.fin) begin
            o_filtered_bitmap <= irbd_pkg::RAW_W'(r_filt);
            o_active_count    <= irbd_pkg::RUN_W'(r_count);
            o_run_start       <= (r_best_len == '0) ? '0 : irbd_pkg::START_W'(r_best_start);
            o_run_length      <= (r_best_len == '0) ? '0 : r_run_len;
            o_ball_seen       <= (r_best_len != '0);
            if ((r_best_len == '0) || ((r_sx == '0) && (r_sy == '0)) ||
                (w_tenths >= irbd_pkg::ANGLE_W'(irbd_pkg::TENTHS_TURN))) begin
                o_angle_tenths <= '0;
            end else begin
                o_angle_tenths <= w_tenths;
            end
        end
    end

    assign o_stat.best_len = (r_best_len > CLW'(SENSORS)) ?
                             irbd_pkg::RUN_W'(SENSORS) : irbd_pkg::RUN_W'(r_best_len);
    assign o_stat.run_len  = r_run_len;

endmodule
`default_nettype wire

// ----- sv/ir_ring_ball_direction_unit.sv -----
// Top level of the IR ring ball direction unit
// One raw scan item is taken when the block is idle. Its result item follows the
// circular run search, the vector sum and atan2, or follows the run search
// directly when no sensor is filtered active. The one-sensor-per-cycle circular
// run search, one table read per cycle for the vector sum and the 24 iterations
// of the iterative CORDIC atan2 unit make up this work. An item holds the block
// from the idle cycle that takes it until its result is handed to the output
// register. The result waits in an output register, so the next scan is taken
// while it is still stalled. Configuration writes are always ready; write them
// only while idle. Sensor counters clear at reset, registers take their reset values.
`timescale 1ns / 1ps
`default_nettype none
module ir_ring_ball_direction_unit #(
    parameter int SENSORS = irbd_pkg::SENSORS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [irbd_pkg::RAW_W-1:0]     i_raw_hits,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [irbd_pkg::RAW_W-1:0]          o_filtered_bitmap,
    output logic [irbd_pkg::RUN_W-1:0]          o_active_count,
    output logic [irbd_pkg::START_W-1:0]        o_run_start,
    output logic [irbd_pkg::RUN_W-1:0]          o_run_length,
    output logic                                o_ball_seen,
    output logic [irbd_pkg::ANGLE_W-1:0]        o_angle_tenths,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [irbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [irbd_pkg::CFG_W-1:0]     i_cfg_data
);

    irbd_pkg::t_cmd  w_cmd;
    irbd_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    irbd_ctrl #(
        .SENSORS (SENSORS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    irbd_datapath #(
        .SENSORS (SENSORS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_raw_hits        (i_raw_hits),
        .o_filtered_bitmap (o_filtered_bitmap),
        .o_active_count    (o_active_count),
        .o_run_start       (o_run_start),
        .o_run_length      (o_run_length),
        .o_ball_seen       (o_ball_seen),
        .o_angle_tenths    (o_angle_tenths)
    );

endmodule
`default_nettype wire

// ----- sv/irbd_checker.sv -----
// Port checker of the IR ring ball direction unit and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "ir_ring_ball_direction_unit_macros.svh"
module irbd_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_valid,
    input wire logic                           o_stall,
    input wire logic                           o_valid,
    input wire logic                           i_stall,
    input wire logic [irbd_pkg::RUN_W-1:0]     o_active_count,
    input wire logic [irbd_pkg::START_W-1:0]   o_run_start,
    input wire logic [irbd_pkg::RUN_W-1:0]     o_run_length,
    input wire logic                           o_ball_seen,
    input wire logic [irbd_pkg::ANGLE_W-1:0]   o_angle_tenths
);

    `IRBD_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "no stall after item accepted")
    `IRBD_ASSERT_IMPL(a_no_ball_zero, o_valid && !o_ball_seen, (o_run_start == '0) && (o_run_length == '0) && (o_angle_tenths == '0), "fields not zero without ball")
    `IRBD_ASSERT_IMPL(a_run_fits, o_valid, (o_run_length <= o_active_count) && (o_ball_seen == (o_run_length != '0)) && (o_angle_tenths < 12'd3600), "result fields inconsistent")
    `IRBD_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_angle_tenths), "stalled result dropped or changed")

endmodule

bind ir_ring_ball_direction_unit irbd_checker u_irbd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_active_count (o_active_count),
    .o_run_start    (o_run_start),
    .o_run_length   (o_run_length),
    .o_ball_seen    (o_ball_seen),
    .o_angle_tenths (o_angle_tenths)
);
`default_nettype wire

// ----- test/ir_ring_ball_direction_unit_test.sv -----
// Testbench for the IR ring ball direction unit: scoreboard against a local prediction
`timescale 1ns / 1ps
`default_nettype none
module ir_ring_ball_direction_unit_test;

    localparam int RING = 16;
    localparam int LONG_HOLD = 400;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [irbd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [irbd_pkg::RAW_W-1:0]   filt;
        logic [irbd_pkg::RUN_W-1:0]   count;
        logic [irbd_pkg::START_W-1:0] start;
        logic [irbd_pkg::RUN_W-1:0]   len;
        logic                         seen;
        logic [irbd_pkg::ANGLE_W-1:0] tenths;
    } t_scan_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [irbd_pkg::RAW_W-1:0] i_raw_hits = '0;
    logic i_stall = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [irbd_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [irbd_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic o_stall, o_valid, o_ball_seen, o_cfg_ready;
    logic [irbd_pkg::RAW_W-1:0] o_filtered_bitmap;
    logic [irbd_pkg::RUN_W-1:0] o_active_count, o_run_length;
    logic [irbd_pkg::START_W-1:0] o_run_start;
    logic [irbd_pkg::ANGLE_W-1:0] o_angle_tenths;

    ir_ring_ball_direction_unit dut (.*);

    logic [7:0] conf [RING];
    logic [7:0] streak [RING];
    logic [7:0] ceiling_reg = irbd_pkg::CEILING_RST;
    logic [7:0] decay_reg = irbd_pkg::MISSES_RST;
    logic [7:0] thresh_reg = irbd_pkg::THRESHOLD_RST;

    t_scan_result expected_scans[$];
    int errors = 0;
    int cycles = 0;
    bit quiet = 0;
    bit hold_long = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic longint round_q15(longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function automatic void sensor_vector(int idx, output longint c, output longint s);
        logic [31:0] ang;
        longint x, y, z, dx, dy;
        ang = 32'((((64'(idx)) << 32) + RING / 2) / RING);
        z = longint'(ang[29:0]);
        x = irbd_pkg::CORDIC_START;
        y = 0;
        for (int i = 0; i < irbd_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(irbd_pkg::ATAN_TURN[i]);
            end else begin
                x += dx; y -= dy; z += longint'(irbd_pkg::ATAN_TURN[i]);
            end
        end
        case (ang[31:30])
            2'd0: begin c = round_q15(x); s = round_q15(y); end
            2'd1: begin c = round_q15(-y); s = round_q15(x); end
            2'd2: begin c = round_q15(-x); s = round_q15(-y); end
            default: begin c = round_q15(y); s = round_q15(-x); end
        endcase
    endfunction

    function automatic logic [irbd_pkg::ANGLE_W-1:0] bearing_tenths(longint sx, longint sy);
        longint x, y, dx, dy;
        logic [31:0] z;
        logic [63:0] p;
        x = sx * 4096;
        y = sy * 4096;
        z = 32'd0;
        if (x < 0) begin
            x = -x; y = -y; z = 32'h8000_0000;
        end
        for (int i = 0; i < irbd_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x -= dx; y += dy; z -= irbd_pkg::ATAN_TURN[i];
            end else begin
                x += dx; y -= dy; z += irbd_pkg::ATAN_TURN[i];
            end
        end
        p = (64'(z) * 64'd3600 + 64'h8000_0000) >> 32;
        if (p >= 64'd3600) p = 0;
        return p[irbd_pkg::ANGLE_W-1:0];
    endfunction

    function automatic t_scan_result predict_scan(logic [irbd_pkg::RAW_W-1:0] raw);
        t_scan_result r;
        int best_start, best_len, cur_start, cur_len, idx;
        longint sx, sy, c, s;
        r.filt = '0;
        r.count = '0;
        for (int i = 0; i < RING; i++) begin
            if (raw[i]) begin
                streak[i] = 8'd0;
                if (conf[i] < ceiling_reg) conf[i]++;
            end else begin
                streak[i] = streak[i] + 8'd1;
                if (streak[i] >= decay_reg) begin
                    if (conf[i] > 0) conf[i]--;
                    streak[i] = 8'd0;
                end
            end
            if (conf[i] >= thresh_reg) begin
                r.filt[i] = 1'b1;
                r.count++;
            end
        end
        best_start = 0; best_len = 0; cur_start = 0; cur_len = 0;
        for (int k = 0; k < 2 * RING; k++) begin
            idx = k % RING;
            if (r.filt[idx]) begin
                if (cur_len == 0) cur_start = idx;
                cur_len++;
                if (cur_len > best_len) begin
                    best_len = cur_len;
                    best_start = cur_start;
                end
            end else begin
                cur_len = 0;
            end
        end
        if (best_len > RING) best_len = RING;
        r.tenths = '0;
        if (best_len > 0) begin
            sx = 0; sy = 0;
            for (int k = 0; k < best_len; k++) begin
                sensor_vector((best_start + k) % RING, c, s);
                sx += c;
                sy += s;
            end
            if (sx != 0 || sy != 0) r.tenths = bearing_tenths(sx, sy);
        end else begin
            best_start = 0;
        end
        r.start = best_start[irbd_pkg::START_W-1:0];
        r.len = best_len[irbd_pkg::RUN_W-1:0];
        r.seen = (best_len > 0);
        return r;
    endfunction

    task automatic send_scan(logic [irbd_pkg::RAW_W-1:0] raw);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_raw_hits <= raw;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_scans.push_back(predict_scan(raw));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_scans.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [irbd_pkg::CFG_IDX_W-1:0] idx,
                             logic [irbd_pkg::CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            irbd_pkg::CFG_CEILING:   ceiling_reg = data;
            irbd_pkg::CFG_MISSES:    decay_reg = data;
            irbd_pkg::CFG_THRESHOLD: thresh_reg = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic [7:0] ceil, logic [7:0] miss, logic [7:0] thr);
        wait_idle();
        write_reg(irbd_pkg::CFG_CEILING, ceil);
        write_reg(irbd_pkg::CFG_MISSES, miss);
        write_reg(irbd_pkg::CFG_THRESHOLD, thr);
    endtask

    function automatic logic [irbd_pkg::RAW_W-1:0] arc_scan();
        logic [irbd_pkg::RAW_W-1:0] v;
        int st, len;
        v = '0;
        st = $urandom_range(0, RING - 1);
        len = $urandom_range(0, RING);
        for (int k = 0; k < len; k++) v[(st + k) % RING] = 1'b1;
        if ($urandom_range(0, 3) == 0) v[$urandom_range(0, RING - 1)] ^= 1'b1;
        return v;
    endfunction

    task automatic test_directed_scans();
        logic [irbd_pkg::RAW_W-1:0] pats [12] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
            16'h8001, 16'h8001, 16'h8001, 16'h0101, 16'h5555, 16'hAAAA, 16'h00F0, 16'h0000};
        foreach (pats[i]) send_scan(pats[i]);
        for (int i = 0; i < 4; i++) send_scan(16'hFF00);
    endtask

    task automatic test_register_extremes();
        set_regs(8'd0, 8'd0, 8'd0);
        send_scan(16'hFFFF);
        send_scan(16'h1234);
        wait_idle();
        write_reg(CFG_UNUSED, 8'hFF);
        set_regs(8'd255, 8'd255, 8'd255);
        for (int i = 0; i < 3; i++) send_scan(16'h0F0F);
        set_regs(8'd6, 8'd1, 8'd1);
        for (int i = 0; i < 6; i++) send_scan(16'h3C3C);
        set_regs(8'd2, 8'd2, 8'd2);
        send_scan(16'h3C3C);
        send_scan(16'h0000);
        send_scan(16'hC3C3);
    endtask

    task automatic test_random_scans(int n);
        logic [7:0] ceil, thr;
        for (int ph = 0; ph < 8; ph++) begin
            ceil = 8'($urandom_range(1, 8));
            thr = 8'($urandom_range(0, ceil));
            if (ph == 6) set_regs(8'd255, 8'd1, 8'd0);
            else if (ph == 7) set_regs(8'd1, 8'd255, 8'd1);
            else set_regs(ceil, 8'($urandom_range(1, 6)), thr);
            for (int i = 0; i < n / 8; i++) begin
                quiet = ($urandom_range(0, 9) == 0) ? ~quiet : quiet;
                if ($urandom_range(0, 4) == 0) begin
                    send_scan(irbd_pkg::RAW_W'($urandom_range(0, 16'hFFFF)));
                end else begin
                    send_scan(arc_scan());
                end
            end
            quiet = 0;
        end
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        hold_long = 1;
        quiet = 1;
        for (int i = 0; i < 30; i++) send_scan(arc_scan());
        quiet = 0;
    endtask

    initial begin
        for (int i = 0; i < RING; i++) begin
            conf[i] = 8'd0;
            streak[i] = 8'd0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_scans();
        test_register_extremes();
        test_output_backpressure();
        test_random_scans(2000);
        wait_idle();
        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_scans.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            n = hold_long ? LONG_HOLD : (quiet ? 0 : $urandom_range(0, 11));
            hold_long = 0;
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_scan_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_scans.size() == 0) begin
                $display("%0t: unexpected result item", $time);
                errors++;
            end else begin
                e = expected_scans.pop_front();
                if (o_filtered_bitmap !== e.filt) begin
                    $display("%0t: filtered_bitmap exp %h got %h", $time, e.filt,
                             o_filtered_bitmap);
                    errors++;
                end
                if (o_active_count !== e.count) begin
                    $display("%0t: active_count exp %0d got %0d", $time, e.count,
                             o_active_count);
                    errors++;
                end
                if (o_run_start !== e.start) begin
                    $display("%0t: run_start exp %0d got %0d", $time, e.start, o_run_start);
                    errors++;
                end
                if (o_run_length !== e.len) begin
                    $display("%0t: run_length exp %0d got %0d", $time, e.len, o_run_length);
                    errors++;
                end
                if (o_ball_seen !== e.seen) begin
                    $display("%0t: ball_seen exp %0d got %0d", $time, e.seen, o_ball_seen);
                    errors++;
                end
                if (o_angle_tenths !== e.tenths) begin
                    $display("%0t: angle_tenths exp %0d got %0d", $time, e.tenths,
                             o_angle_tenths);
                    errors++;
                end
            end
        end
    end

endmodule
`default_nettype wire
